[rtl/core/jobf_pkg.sv]
package jobf_pkg;

  // Field and register widths of the framer.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned DEPTH_W = 8;

  // Value of the length limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Brace codes that open and close an object.
  localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] CLOSE_BRACE = 8'h7D;

  // Controller state: gathering an object, or replaying a finished one.
  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } jobf_state_t;

endpackage

[rtl/core/jobf_if.sv]
// Input channel: one raw stream byte per word.
interface jobf_in_if
  import jobf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// Result channel: one byte of a completed object per word.
interface jobf_out_if
  import jobf_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              object_end;

  modport source (output valid, output byte_out, output object_end, input ready);
  modport sink   (input valid, input byte_out, input object_end, output ready);
endinterface

[rtl/core/jobf_ram.sv]
module jobf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port; the read data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/json_object_brace_framer_unit.sv]
// Channel   Direction  Payload                        Handshake
// in_ch     sink       byte_in[7:0]                   valid / ready
// out_ch    source     byte_out[7:0], object_end      valid / ready
// cfg       write      cfg_wdata[6:0] (length limit)  cfg_we, no wait
//
// While gathering an object, one byte is taken every cycle that in_ch is valid,
// and each byte that fits is written to the buffer RAM at the fill count. When an
// accepted object closes, the input stalls and the RAM is read back one byte a
// cycle while out_ch is ready, through the RAM read register and output register.
// out_ch stalls hold the RAM read register and the output register.
// The buffer needs no clearing pass after reset; rst_n clears the control state.
module json_object_brace_framer_unit
  import jobf_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned DEPTH_LIMIT  = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  jobf_in_if.sink            in_ch,
  jobf_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned FILL_W = $clog2(BUFFER_BYTES + 1);

  jobf_state_t           state_r, state_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [FILL_W-1:0]     len_r, len_nxt;
  logic [FILL_W-1:0]     rd_r, rd_nxt;
  logic [LIMIT_W-1:0]    size_limit_r;

  // Read pipeline: RAM read register, then the output register.
  logic                  rv_r, rv_nxt;
  logic                  rlast_r, rlast_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [BYTE_W-1:0]     out_data_r;
  logic                  out_end_r;

  logic                  in_take;
  logic                  out_take;
  logic                  move;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_re;
  logic [BYTE_W-1:0]     ram_rdata;

  jobf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.byte_in),
    .re    (ram_re),
    .raddr (rd_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready      = (state_r == ST_COLLECT);
  assign in_take          = in_ch.valid && in_ch.ready;
  assign out_take         = out_v_r && out_ch.ready;
  assign move             = rv_r && (!out_v_r || out_take);
  assign out_ch.valid     = out_v_r;
  assign out_ch.byte_out  = out_data_r;
  assign out_ch.object_end = out_end_r;

  // Brace tracking, buffer writes and read-back sequencing.
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    len_nxt   = len_r;
    rd_nxt    = rd_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[ADDR_W-1:0];
    ram_re    = 1'b0;
    rlast_nxt = rlast_r;
    rv_nxt    = move ? 1'b0 : rv_r;

    unique case (state_r)
      ST_COLLECT: begin
        if (in_take) begin
          if (depth_r == '0) begin
            // Outside an object only an opening brace matters.
            if (in_ch.byte_in == OPEN_BRACE) begin
              depth_nxt = DEPTH_W'(1);
              ram_we    = 1'b1;
              ram_waddr = '0;
              fill_nxt  = FILL_W'(1);
              ovf_nxt   = 1'b0;
            end
          end else begin
            // Store the byte, or mark the object as too long for the buffer.
            if (fill_r < FILL_W'(BUFFER_BYTES)) begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_ch.byte_in == OPEN_BRACE) begin
              if (depth_r < DEPTH_W'(DEPTH_LIMIT)) begin
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end else if (in_ch.byte_in == CLOSE_BRACE) begin
              depth_nxt = depth_r - DEPTH_W'(1);
              if (depth_r == DEPTH_W'(1)) begin
                // Object complete: replay it if it did not overflow and is shorter than the length limit.
                if (!ovf_nxt && (LIMIT_W'(fill_nxt) < size_limit_r)) begin
                  len_nxt   = fill_nxt;
                  rd_nxt    = '0;
                  state_nxt = ST_EMIT;
                end
                fill_nxt = '0;
                ovf_nxt  = 1'b0;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        // Issue a read whenever the RAM read register is free or draining.
        if (!rv_r || move) begin
          ram_re    = 1'b1;
          rv_nxt    = 1'b1;
          rd_nxt    = rd_r + FILL_W'(1);
          rlast_nxt = (rd_r == len_r - FILL_W'(1));
          if (rd_r == len_r - FILL_W'(1)) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase

    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_take) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      depth_r      <= '0;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      rd_r         <= '0;
      rv_r         <= 1'b0;
      out_v_r      <= 1'b0;
      size_limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      rd_r    <= rd_nxt;
      rv_r    <= rv_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        size_limit_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    rlast_r <= rlast_nxt;
    if (move) begin
      out_data_r <= ram_rdata;
      out_end_r  <= rlast_r;
    end
  end

`ifndef SYNTHESIS
  // The buffer is never written and read back in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
    else $error("buffer written and read in the same cycle");

  // A RAM word that cannot move on keeps its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !move) |=> (rv_r && $stable(ram_rdata)))
    else $error("pending read word lost");

  // The fill count never passes the buffer size.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUFFER_BYTES))
    else $error("fill count beyond buffer size");

  // A stalled output word keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(out_data_r) && $stable(out_end_r)))
    else $error("stalled output word changed");
`endif

endmodule
